@@ design/adab_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package adab_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;

    localparam int PIX_W       = 12;
    localparam int CRD_W       = 14;
    localparam int CH_W        = 8;
    localparam int CH_MAX      = 255;
    localparam int RAD_W       = 16;
    localparam int OPA_W       = 16;
    localparam int OPA_FRAC    = 14;
    localparam int COL_W       = 16;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int RST_RADIUS  = 256;
    localparam int RST_OPACITY = 16384;
    localparam int RST_COLOR   = 32768;

    // offsets in half pixels
    localparam int OFS_W       = 16;
    localparam int SQ1_W       = 30;
    localparam int SQR_W       = SQ1_W + 1;
    localparam int SQRT_SHIFT  = 14;

    localparam int ROOT_W      = 24;
    localparam int RADICAND_W  = 2 * ROOT_W;
    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STG    = ROOT_W / SQRT_STEPS;
    localparam int SREM_W      = ROOT_W + 2;

    // inside term: 3*d*2^16 / (20*r), quotient below 2^14
    localparam int ALPHA_FRAC  = 16;
    localparam int QUO_W       = 14;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_STG     = QUO_W / DIV_STEPS;
    localparam int DEN_W       = 21;
    localparam int DREM_W      = DEN_W + 1;
    localparam int D3_W        = RAD_W + 2;

    // alpha stages: compare and set-up, quotient stages, opacity
    localparam int ALPHA_STG   = DIV_STG + 2;

    localparam int ALPHA_W     = ALPHA_FRAC + 1;
    localparam int ALPHA_ONE   = 65536;
    localparam int ALPHA_MIN   = 196;

    // ring term: 576*(512-e)/5, /5 by reciprocal ceil(2^22/5), exact below 2^22
    localparam int RING_LEN    = 512;
    localparam int RING_V_W    = 10;
    localparam int RING_X_W    = 19;
    localparam int RING_GAIN   = 576;
    localparam int RECIP5      = 838861;
    localparam int RECIP5_W    = 20;
    localparam int RECIP5_SH   = 22;
    localparam int RING_PROD_W = RING_X_W + RECIP5_W;
    localparam int RING_W      = 16;

    localparam int AMUL_W      = ALPHA_W + OPA_W;
    localparam int ASCALED_W   = AMUL_W - OPA_FRAC;
    localparam int CMUL_W      = ALPHA_W + COL_W;
    localparam int CADD_W      = 10;
    localparam int CSUM_W      = CADD_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_RADIUS_Q8   = 3'd2,
        CFG_OPACITY_Q14 = 3'd3,
        CFG_COLOR_RED   = 3'd4,
        CFG_COLOR_GREEN = 3'd5,
        CFG_COLOR_BLUE  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] center_x;
        logic signed [CRD_W-1:0] center_y;
        logic [RAD_W-1:0]        radius_q8;
        logic [OPA_W-1:0]        opacity_q14;
        logic [COL_W-1:0]        color_red;
        logic [COL_W-1:0]        color_green;
        logic [COL_W-1:0]        color_blue;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0] cur_red;
        logic [CH_W-1:0] cur_green;
        logic [CH_W-1:0] cur_blue;
        logic            in_frame;
    } pix_side_t;

endpackage

`default_nettype wire

@@ design/antialiased_disk_additive_blend_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Soft-edged disk, additive splat over a pixel stream. One pixel is taken per
// clock while the first stage is not held by back-pressure, and one result is
// given per pixel, in order. Each pixel passes through the offsets and squared
// distance, the 24-bit square root (two root digits per stage), the radius
// compare, the 14-bit inside-term quotient (two bits per stage) and the opacity
// multiply, and then the colour multiply and saturating add, the last of which
// is the output register. Back-pressure holds each full stage that has only
// full stages ahead of it; empty stages keep filling, so a request is still
// taken while a finished result waits. Registers are written through
// cfg_wr_en/cfg_index/cfg_data and must only change while no pixel is in flight.

module antialiased_disk_additive_blend_core
    import adab_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  pix_valid,
    output logic                       pix_ready,
    input  wire logic [PIX_W-1:0]      pixel_x,
    input  wire logic [PIX_W-1:0]      pixel_y,
    input  wire logic [CH_W-1:0]       cur_red,
    input  wire logic [CH_W-1:0]       cur_green,
    input  wire logic [CH_W-1:0]       cur_blue,

    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic [CH_W-1:0]            new_red,
    output logic [CH_W-1:0]            new_green,
    output logic [CH_W-1:0]            new_blue,
    output logic                       touched,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic signed [CRD_W-1:0] center_x_reg;
    logic signed [CRD_W-1:0] center_y_reg;
    logic [RAD_W-1:0]        radius_q8_reg;
    logic [OPA_W-1:0]        opacity_q14_reg;
    logic [COL_W-1:0]        color_red_reg;
    logic [COL_W-1:0]        color_green_reg;
    logic [COL_W-1:0]        color_blue_reg;
    cfg_t                    cfg;

    pix_side_t               side_in;
    logic                    dist_valid;
    logic                    dist_ready;
    logic [RADICAND_W-1:0]   radicand;
    pix_side_t               dist_side;
    logic                    sqrt_valid;
    logic                    sqrt_ready;
    logic [ROOT_W-1:0]       root;
    pix_side_t               sqrt_side;
    logic                    alpha_valid;
    logic                    alpha_ready;
    logic [ASCALED_W-1:0]    alpha_scaled;
    pix_side_t               alpha_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            radius_q8_reg   <= RAD_W'(RST_RADIUS);
            opacity_q14_reg <= OPA_W'(RST_OPACITY);
            color_red_reg   <= COL_W'(RST_COLOR);
            color_green_reg <= COL_W'(RST_COLOR);
            color_blue_reg  <= COL_W'(RST_COLOR);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X:    center_x_reg    <= cfg_data[CRD_W-1:0];
                CFG_CENTER_Y:    center_y_reg    <= cfg_data[CRD_W-1:0];
                CFG_RADIUS_Q8:   radius_q8_reg   <= cfg_data[RAD_W-1:0];
                CFG_OPACITY_Q14: opacity_q14_reg <= cfg_data[OPA_W-1:0];
                CFG_COLOR_RED:   color_red_reg   <= cfg_data[COL_W-1:0];
                CFG_COLOR_GREEN: color_green_reg <= cfg_data[COL_W-1:0];
                CFG_COLOR_BLUE:  color_blue_reg  <= cfg_data[COL_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg.center_x    = center_x_reg;
        cfg.center_y    = center_y_reg;
        cfg.radius_q8   = radius_q8_reg;
        cfg.opacity_q14 = opacity_q14_reg;
        cfg.color_red   = color_red_reg;
        cfg.color_green = color_green_reg;
        cfg.color_blue  = color_blue_reg;

        side_in.cur_red   = cur_red;
        side_in.cur_green = cur_green;
        side_in.cur_blue  = cur_blue;
        side_in.in_frame  = (32'(pixel_x) < MAX_WIDTH) && (32'(pixel_y) < MAX_HEIGHT);
    end

    adab_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .src_valid (pix_valid),
        .src_ready (pix_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .side_in   (side_in),
        .dst_valid (dist_valid),
        .dst_ready (dist_ready),
        .radicand  (radicand),
        .side_out  (dist_side)
    );

    adab_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (dist_valid),
        .src_ready (dist_ready),
        .radicand  (radicand),
        .side_in   (dist_side),
        .dst_valid (sqrt_valid),
        .dst_ready (sqrt_ready),
        .root      (root),
        .side_out  (sqrt_side)
    );

    adab_alpha u_alpha (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .src_valid    (sqrt_valid),
        .src_ready    (sqrt_ready),
        .dist_q8      (root),
        .side_in      (sqrt_side),
        .dst_valid    (alpha_valid),
        .dst_ready    (alpha_ready),
        .alpha_scaled (alpha_scaled),
        .side_out     (alpha_side)
    );

    adab_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .src_valid    (alpha_valid),
        .src_ready    (alpha_ready),
        .alpha_scaled (alpha_scaled),
        .side_in      (alpha_side),
        .dst_valid    (res_valid),
        .dst_ready    (res_ready),
        .new_red      (new_red),
        .new_green    (new_green),
        .new_blue     (new_blue),
        .touched      (touched)
    );

endmodule

`default_nettype wire

@@ design/adab_dist.sv @@
`timescale 1ns / 1ps
`default_nettype none

module adab_dist
    import adab_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              src_valid,
    output logic                   src_ready,
    input  wire logic [PIX_W-1:0]  pixel_x,
    input  wire logic [PIX_W-1:0]  pixel_y,
    input  wire pix_side_t         side_in,
    output logic                   dst_valid,
    input  wire logic              dst_ready,
    output logic [RADICAND_W-1:0]  radicand,
    output pix_side_t              side_out
);

    logic [2:0]               valid_reg;
    logic [2:0]               rdy;
    logic signed [OFS_W-1:0]  dx_reg;
    logic signed [OFS_W-1:0]  dy_reg;
    logic signed [OFS_W-1:0]  dx_next;
    logic signed [OFS_W-1:0]  dy_next;
    logic signed [2*OFS_W-1:0] sqx_full;
    logic signed [2*OFS_W-1:0] sqy_full;
    logic [SQ1_W-1:0]         sqx_reg;
    logic [SQ1_W-1:0]         sqy_reg;
    logic [SQR_W-1:0]         sum;
    logic [RADICAND_W-1:0]    rad_reg;
    logic [RADICAND_W-1:0]    rad_next;
    pix_side_t                side_reg [3];

    assign rdy[2]    = !valid_reg[2] || dst_ready;
    assign rdy[1]    = !valid_reg[1] || rdy[2];
    assign rdy[0]    = !valid_reg[0] || rdy[1];
    assign src_ready = rdy[0];

    always_comb
    begin
        dx_next = $signed({{(OFS_W-PIX_W-1){1'b0}}, pixel_x, 1'b1})
                - $signed({{(OFS_W-CRD_W-1){cfg.center_x[CRD_W-1]}}, cfg.center_x, 1'b0});
        dy_next = $signed({{(OFS_W-PIX_W-1){1'b0}}, pixel_y, 1'b1})
                - $signed({{(OFS_W-CRD_W-1){cfg.center_y[CRD_W-1]}}, cfg.center_y, 1'b0});
        sqx_full = dx_reg * dx_reg;
        sqy_full = dy_reg * dy_reg;
        sum      = SQR_W'(sqx_reg) + SQR_W'(sqy_reg);
        rad_next = RADICAND_W'({sum, {SQRT_SHIFT{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= src_valid;
            end
            if (rdy[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (rdy[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            side_reg[0] <= side_in;
        end
        if (rdy[1])
        begin
            sqx_reg     <= sqx_full[SQ1_W-1:0];
            sqy_reg     <= sqy_full[SQ1_W-1:0];
            side_reg[1] <= side_reg[0];
        end
        if (rdy[2])
        begin
            rad_reg     <= rad_next;
            side_reg[2] <= side_reg[1];
        end
    end

    assign dst_valid = valid_reg[2];
    assign radicand  = rad_reg;
    assign side_out  = side_reg[2];

endmodule

`default_nettype wire

@@ design/adab_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module adab_sqrt
    import adab_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  src_valid,
    output logic                       src_ready,
    input  wire logic [RADICAND_W-1:0] radicand,
    input  wire pix_side_t             side_in,
    output logic                       dst_valid,
    input  wire logic                  dst_ready,
    output logic [ROOT_W-1:0]          root,
    output pix_side_t                  side_out
);

    typedef struct packed {
        logic [RADICAND_W-1:0] rad;
        logic [SREM_W-1:0]     rem;
        logic [ROOT_W-1:0]     root;
    } sq_stage_t;

    sq_stage_t             stg_src  [SQRT_STG];
    sq_stage_t             stg_next [SQRT_STG];
    sq_stage_t             stg_reg  [SQRT_STG];
    pix_side_t             side_src [SQRT_STG];
    pix_side_t             side_reg [SQRT_STG];
    logic [SQRT_STG-1:0]   valid_src;
    logic [SQRT_STG-1:0]   valid_reg;
    logic [SQRT_STG-1:0]   rdy;

    // one root digit: bring down two radicand bits, trial subtract
    function automatic sq_stage_t sqrt_step(input sq_stage_t s);
        sq_stage_t         o;
        logic [SREM_W-1:0] t;
        logic [SREM_W-1:0] trial;
        t     = {s.rem[SREM_W-3:0], s.rad[RADICAND_W-1 -: 2]};
        trial = {s.root, 2'b01};
        o.rad = {s.rad[RADICAND_W-3:0], 2'b00};
        if (t >= trial)
        begin
            o.rem  = t - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = t;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic sq_stage_t sqrt_steps(input sq_stage_t s);
        sq_stage_t o;
        o = s;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            o = sqrt_step(o);
        end
        return o;
    endfunction

    for (genvar i = 0; i < SQRT_STG; i++)
    begin : g_stg
        if (i == 0)
        begin : g_first
            assign stg_src[i]   = {radicand, {SREM_W{1'b0}}, {ROOT_W{1'b0}}};
            assign side_src[i]  = side_in;
            assign valid_src[i] = src_valid;
        end
        else
        begin : g_next
            assign stg_src[i]   = stg_reg[i-1];
            assign side_src[i]  = side_reg[i-1];
            assign valid_src[i] = valid_reg[i-1];
        end

        if (i == SQRT_STG - 1)
        begin : g_last_rdy
            assign rdy[i] = !valid_reg[i] || dst_ready;
        end
        else
        begin : g_mid_rdy
            assign rdy[i] = !valid_reg[i] || rdy[i+1];
        end

        assign stg_next[i] = sqrt_steps(stg_src[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (rdy[i])
            begin
                valid_reg[i] <= valid_src[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i])
            begin
                stg_reg[i]  <= stg_next[i];
                side_reg[i] <= side_src[i];
            end
        end
    end

    assign src_ready = rdy[0];
    assign dst_valid = valid_reg[SQRT_STG-1];
    assign root      = stg_reg[SQRT_STG-1].root;
    assign side_out  = side_reg[SQRT_STG-1];

endmodule

`default_nettype wire

@@ design/adab_alpha.sv @@
`timescale 1ns / 1ps
`default_nettype none

module adab_alpha
    import adab_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              src_valid,
    output logic                   src_ready,
    input  wire logic [ROOT_W-1:0] dist_q8,
    input  wire pix_side_t         side_in,
    output logic                   dst_valid,
    input  wire logic              dst_ready,
    output logic [ASCALED_W-1:0]   alpha_scaled,
    output pix_side_t              side_out
);

    typedef struct packed {
        logic [DREM_W-1:0]   rem;
        logic [RING_X_W-1:0] x;
        logic                in_disk;
        logic                ring_on;
    } pp_t;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic [RING_W-1:0] ring;
        logic              in_disk;
        logic              ring_on;
    } dv_stage_t;

    logic [ALPHA_STG-1:0] valid_src;
    logic [ALPHA_STG-1:0] valid_reg;
    logic [ALPHA_STG-1:0] rdy;
    pix_side_t            side_src [ALPHA_STG];
    pix_side_t            side_reg [ALPHA_STG];

    pp_t                  pp_next;
    pp_t                  pp_reg;
    logic [ROOT_W-1:0]    r_ext;
    logic [ROOT_W-1:0]    e;
    logic [RING_V_W-1:0]  v;
    logic [D3_W-1:0]      d3;
    logic [DEN_W-1:0]     den;
    logic [DREM_W-1:0]    den_ext;
    logic                 r_zero;

    dv_stage_t            dv_src  [DIV_STG];
    dv_stage_t            dv_next [DIV_STG];
    dv_stage_t            dv_reg  [DIV_STG];

    dv_stage_t            dv_last;
    logic [ALPHA_W-1:0]   alpha;
    logic [AMUL_W-1:0]    amul;
    logic [ASCALED_W-1:0] a_reg;

    function automatic logic [RING_W-1:0] ring_of(input logic [RING_X_W-1:0] x);
        logic [RING_PROD_W-1:0] p;
        p = RING_PROD_W'(x) * RING_PROD_W'(RECIP5);
        return p[RECIP5_SH +: RING_W];
    endfunction

    function automatic dv_stage_t div_steps(input dv_stage_t s, input logic [DREM_W-1:0] dv);
        dv_stage_t         o;
        logic [DREM_W-1:0] t;
        o = s;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            t = {o.rem[DREM_W-2:0], 1'b0};
            if (t >= dv)
            begin
                o.rem = t - dv;
                o.quo = {o.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                o.rem = t;
                o.quo = {o.quo[QUO_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    always_comb
    begin
        r_ext           = ROOT_W'(cfg.radius_q8);
        e               = dist_q8 - r_ext;
        v               = RING_V_W'(RING_LEN) - e[RING_V_W-1:0];
        d3              = D3_W'(dist_q8[RAD_W-1:0]) + D3_W'({dist_q8[RAD_W-1:0], 1'b0});
        pp_next.in_disk = dist_q8 <= r_ext;
        pp_next.ring_on = (dist_q8 > r_ext) && (e < ROOT_W'(RING_LEN));
        pp_next.x       = RING_X_W'(v) * RING_X_W'(RING_GAIN);
        pp_next.rem     = DREM_W'({d3, {(ALPHA_FRAC-QUO_W){1'b0}}});
        den             = DEN_W'({cfg.radius_q8, 4'b0000}) + DEN_W'({cfg.radius_q8, 2'b00});
        den_ext         = DREM_W'(den);
        r_zero          = cfg.radius_q8 == '0;
    end

    for (genvar k = 0; k < ALPHA_STG; k++)
    begin : g_ctl
        if (k == 0)
        begin : g_first
            assign valid_src[k] = src_valid;
            assign side_src[k]  = side_in;
        end
        else
        begin : g_next
            assign valid_src[k] = valid_reg[k-1];
            assign side_src[k]  = side_reg[k-1];
        end

        if (k == ALPHA_STG - 1)
        begin : g_last_rdy
            assign rdy[k] = !valid_reg[k] || dst_ready;
        end
        else
        begin : g_mid_rdy
            assign rdy[k] = !valid_reg[k] || rdy[k+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                valid_reg[k] <= valid_src[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                side_reg[k] <= side_src[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pp_reg <= pp_next;
        end
    end

    for (genvar j = 0; j < DIV_STG; j++)
    begin : g_div
        if (j == 0)
        begin : g_first
            assign dv_src[j] = {pp_reg.rem, {QUO_W{1'b0}}, ring_of(pp_reg.x),
                                pp_reg.in_disk, pp_reg.ring_on};
        end
        else
        begin : g_next
            assign dv_src[j] = dv_reg[j-1];
        end

        assign dv_next[j] = div_steps(dv_src[j], den_ext);

        always_ff @(posedge clk)
        begin
            if (rdy[j+1])
            begin
                dv_reg[j] <= dv_next[j];
            end
        end
    end

    always_comb
    begin
        dv_last = dv_reg[DIV_STG-1];
        if (dv_last.in_disk)
        begin
            if (r_zero)
            begin
                alpha = ALPHA_W'(ALPHA_ONE);
            end
            else
            begin
                alpha = ALPHA_W'(ALPHA_ONE) - ALPHA_W'(dv_last.quo);
            end
        end
        else if (dv_last.ring_on)
        begin
            alpha = ALPHA_W'(dv_last.ring);
        end
        else
        begin
            alpha = '0;
        end
        amul = AMUL_W'(alpha) * AMUL_W'(cfg.opacity_q14);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ALPHA_STG-1])
        begin
            a_reg <= amul[AMUL_W-1:OPA_FRAC];
        end
    end

    assign src_ready    = rdy[0];
    assign dst_valid    = valid_reg[ALPHA_STG-1];
    assign alpha_scaled = a_reg;
    assign side_out     = side_reg[ALPHA_STG-1];

endmodule

`default_nettype wire

@@ design/adab_blend.sv @@
`timescale 1ns / 1ps
`default_nettype none

module adab_blend
    import adab_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire logic                 src_valid,
    output logic                      src_ready,
    input  wire logic [ASCALED_W-1:0] alpha_scaled,
    input  wire pix_side_t            side_in,
    output logic                      dst_valid,
    input  wire logic                 dst_ready,
    output logic [CH_W-1:0]           new_red,
    output logic [CH_W-1:0]           new_green,
    output logic [CH_W-1:0]           new_blue,
    output logic                      touched
);

    logic [1:0]          valid_reg;
    logic [1:0]          rdy;
    logic [ALPHA_W-1:0]  a;
    logic                touch_next;
    logic                touch_reg;
    logic [CMUL_W-1:0]   pr_r_next;
    logic [CMUL_W-1:0]   pr_g_next;
    logic [CMUL_W-1:0]   pr_b_next;
    logic [CMUL_W-1:0]   pr_r_reg;
    logic [CMUL_W-1:0]   pr_g_reg;
    logic [CMUL_W-1:0]   pr_b_reg;
    pix_side_t           side_reg;
    logic [CH_W-1:0]     red_next;
    logic [CH_W-1:0]     green_next;
    logic [CH_W-1:0]     blue_next;
    logic [CH_W-1:0]     red_reg;
    logic [CH_W-1:0]     green_reg;
    logic [CH_W-1:0]     blue_reg;
    logic                touched_reg;

    // cur + floor(255*a*col / 2^31), saturated
    function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] cur,
                                                 input logic [CMUL_W-1:0] pr);
        logic [CMUL_W+CH_W-1:0] p255;
        logic [CADD_W-1:0]      add;
        logic [CSUM_W-1:0]      s;
        p255 = {pr, {CH_W{1'b0}}} - {{CH_W{1'b0}}, pr};
        add  = p255[CMUL_W+CH_W-1 -: CADD_W];
        s    = CSUM_W'(cur) + CSUM_W'(add);
        return (s > CSUM_W'(CH_MAX)) ? CH_W'(CH_MAX) : s[CH_W-1:0];
    endfunction

    assign rdy[1]    = !valid_reg[1] || dst_ready;
    assign rdy[0]    = !valid_reg[0] || rdy[1];
    assign src_ready = rdy[0];

    always_comb
    begin
        if (alpha_scaled > ASCALED_W'(ALPHA_ONE))
        begin
            a = ALPHA_W'(ALPHA_ONE);
        end
        else
        begin
            a = alpha_scaled[ALPHA_W-1:0];
        end
        touch_next = side_in.in_frame && (a > ALPHA_W'(ALPHA_MIN));
        pr_r_next  = CMUL_W'(a) * CMUL_W'(cfg.color_red);
        pr_g_next  = CMUL_W'(a) * CMUL_W'(cfg.color_green);
        pr_b_next  = CMUL_W'(a) * CMUL_W'(cfg.color_blue);

        if (touch_reg)
        begin
            red_next   = blend_ch(side_reg.cur_red, pr_r_reg);
            green_next = blend_ch(side_reg.cur_green, pr_g_reg);
            blue_next  = blend_ch(side_reg.cur_blue, pr_b_reg);
        end
        else
        begin
            red_next   = side_reg.cur_red;
            green_next = side_reg.cur_green;
            blue_next  = side_reg.cur_blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= src_valid;
            end
            if (rdy[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            touch_reg <= touch_next;
            pr_r_reg  <= pr_r_next;
            pr_g_reg  <= pr_g_next;
            pr_b_reg  <= pr_b_next;
            side_reg  <= side_in;
        end
        if (rdy[1])
        begin
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            touched_reg <= touch_reg;
        end
    end

    assign dst_valid = valid_reg[1];
    assign new_red   = red_reg;
    assign new_green = green_reg;
    assign new_blue  = blue_reg;
    assign touched   = touched_reg;

endmodule

`default_nettype wire
